// File: src/falru_pkg.sv
// Shared constants and types for the fully associative LRU cache directory.
package falru_pkg;

    localparam int ENTRIES = 1024;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 40;
    localparam int MEM_W   = ADDR_W + STAMP_W;
    localparam int CAP_W   = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam logic [31:0] MISS_MAX = 32'hFFFF_FFFF;

    // Head of the request queue as seen by the lookup engine
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_req;

endpackage

// File: src/falru_queue.sv
// Front end: request queue that accepts block addresses and feeds the engine.
module falru_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [falru_pkg::ADDR_W-1:0] i_block_address,
    output falru_pkg::t_req             o_req,
    input  logic                        i_pop
);

    logic [falru_pkg::ADDR_W-1:0] r_q [falru_pkg::QDEPTH];
    logic [falru_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [falru_pkg::QCNT_W-1:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == falru_pkg::QCNT_W'(falru_pkg::QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    assign o_req.valid = (r_cnt != '0);
    assign o_req.addr  = r_q[r_rp];

    // Store an incoming transfer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_block_address;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == falru_pkg::QPTR_W'(falru_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == falru_pkg::QPTR_W'(falru_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + falru_pkg::QCNT_W'(push) - falru_pkg::QCNT_W'(pop);
        end
    end

endmodule

// File: src/falru_engine.sv
// Back end: scans the tag/stamp memory, picks hit or victim, updates and reports.
module falru_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  falru_pkg::t_req              i_req,
    output logic                         o_pop,
    input  logic [falru_pkg::CAP_W-1:0]  i_cap,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic                         o_evicted_valid,
    output logic [falru_pkg::ADDR_W-1:0] o_evicted_block,
    output logic [31:0]                  o_miss_total
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;

    // Each entry holds {tag, last use stamp}; slots 0..count-1 are resident
    logic [falru_pkg::MEM_W-1:0]   mem [falru_pkg::ENTRIES];
    logic [falru_pkg::MEM_W-1:0]   r_rdata;
    logic                          mem_we;
    logic [falru_pkg::SLOT_W-1:0]  mem_wa;

    logic [falru_pkg::ADDR_W-1:0]  r_addr;
    logic [falru_pkg::CNT_W-1:0]   r_issue;
    logic                          r_rd_pend;
    logic [falru_pkg::SLOT_W-1:0]  r_rd_slot;
    logic                          r_hit;
    logic [falru_pkg::SLOT_W-1:0]  r_hit_slot;
    logic [falru_pkg::STAMP_W-1:0] r_min_stamp;
    logic [falru_pkg::SLOT_W-1:0]  r_min_slot;
    logic [falru_pkg::ADDR_W-1:0]  r_min_tag;
    logic [falru_pkg::CNT_W-1:0]   r_count;
    logic [31:0]                   r_miss;
    logic [falru_pkg::STAMP_W-1:0] r_stamp;

    logic                          r_out_v;
    logic                          r_out_hit;
    logic                          r_out_ev;
    logic [falru_pkg::ADDR_W-1:0]  r_out_blk;
    logic [31:0]                   r_out_miss;

    logic                          issue;
    logic                          full;
    logic                          out_free;
    logic                          finish;
    logic [31:0]                   eff_cap;
    logic [falru_pkg::ADDR_W-1:0]  rd_tag;
    logic [falru_pkg::STAMP_W-1:0] rd_stamp;

    assign rd_tag   = r_rdata[falru_pkg::MEM_W-1:falru_pkg::STAMP_W];
    assign rd_stamp = r_rdata[falru_pkg::STAMP_W-1:0];

    // Clamp capacity to 1..ENTRIES
    always_comb begin
        if (i_cap == '0) begin
            eff_cap = 32'd1;
        end else if (32'(i_cap) > 32'(falru_pkg::ENTRIES)) begin
            eff_cap = 32'(falru_pkg::ENTRIES);
        end else begin
            eff_cap = 32'(i_cap);
        end
    end

    assign full     = (32'(r_count) >= eff_cap);
    assign issue    = (r_state == S_SCAN) && (r_issue < r_count);
    assign out_free = !r_out_v || !i_stall;
    assign finish   = (r_state == S_FIN) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_req.valid;

    // Pick the write slot: hit slot, victim, or the next free slot
    always_comb begin
        mem_we = finish;
        if (r_hit) begin
            mem_wa = r_hit_slot;
        end else if (full) begin
            mem_wa = r_min_slot;
        end else begin
            mem_wa = r_count[falru_pkg::SLOT_W-1:0];
        end
    end

    // Tag and stamp memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= {r_addr, r_stamp};
        end
        r_rdata <= mem[r_issue[falru_pkg::SLOT_W-1:0]];
    end

    // Scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr      <= i_req.addr;
                r_issue     <= '0;
                r_hit       <= 1'b0;
                r_min_stamp <= '1;
            end
            S_SCAN: begin
                if (issue) begin
                    r_rd_slot <= r_issue[falru_pkg::SLOT_W-1:0];
                    r_issue   <= r_issue + 1'b1;
                end
                if (r_rd_pend) begin
                    if (rd_tag == r_addr) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_rd_slot;
                    end
                    if (rd_stamp < r_min_stamp) begin
                        r_min_stamp <= rd_stamp;
                        r_min_slot  <= r_rd_slot;
                        r_min_tag   <= rd_tag;
                    end
                end
            end
            default: begin
            end
        endcase
        if (finish) begin
            r_out_hit  <= r_hit;
            r_out_ev   <= !r_hit && full;
            r_out_blk  <= (!r_hit && full) ? r_min_tag : '0;
            r_out_miss <= (r_hit || r_miss == falru_pkg::MISS_MAX) ? r_miss : r_miss + 32'd1;
        end
    end

    // Control state: sequencer, occupancy, miss count, stamp, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
            r_count   <= '0;
            r_miss    <= '0;
            r_stamp   <= '0;
            r_out_v   <= 1'b0;
        end else begin
            // Load a new result or drop the one just taken
            if (finish) begin
                r_out_v <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_pend <= 1'b0;
                    if (i_req.valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= issue;
                    if (!issue && !r_rd_pend) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_stamp <= r_stamp + 1'b1;
                        if (!r_hit) begin
                            if (r_miss != falru_pkg::MISS_MAX) begin
                                r_miss <= r_miss + 32'd1;
                            end
                            if (!full) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_v;
    assign o_hit           = r_out_hit;
    assign o_evicted_valid = r_out_ev;
    assign o_evicted_block = r_out_blk;
    assign o_miss_total    = r_out_miss;

endmodule

// File: src/fully_associative_lru_cache.sv
// Top level of the fully associative LRU cache directory.
//
// Usage:
//   Input channel: i_valid / o_stall with i_block_address; a transfer happens
//   when i_valid is high and o_stall low. A two-entry queue takes requests
//   while the engine works on an earlier one.
//   Output channel: o_valid / i_stall with o_hit, o_evicted_valid,
//   o_evicted_block and o_miss_total; one result per request, in order.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data sets the
//   capacity in use; o_cfg_ready is always high. Write it only while idle.
// Sequence:
//   For each request the engine takes it from the queue, streams every
//   resident block's entry through the tag/stamp memory's registered read
//   port, then writes the chosen slot and loads the result.
// Reset (synchronous, i_rst_n low) empties the directory, zeroes the miss
// count and sets the capacity to 1024. While i_stall is high the result
// holds; the engine finishes its current scan and then waits.
module fully_associative_lru_cache (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [falru_pkg::ADDR_W-1:0] i_block_address,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic                         o_evicted_valid,
    output logic [falru_pkg::ADDR_W-1:0] o_evicted_block,
    output logic [31:0]                  o_miss_total,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [falru_pkg::CAP_W-1:0]  i_cfg_data
);

    logic [falru_pkg::CAP_W-1:0] r_cap;
    falru_pkg::t_req             req;
    logic                        pop;

    assign o_cfg_ready = 1'b1;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= falru_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    falru_queue u_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_block_address (i_block_address),
        .o_req           (req),
        .i_pop           (pop)
    );

    falru_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req),
        .o_pop           (pop),
        .i_cap           (r_cap),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_block (o_evicted_block),
        .o_miss_total    (o_miss_total)
    );

endmodule

// File: src/falru_checker.sv
// Port-level checks for the cache directory, bound to the top level.
module falru_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_hit,
    input logic                         o_evicted_valid,
    input logic [falru_pkg::ADDR_W-1:0] o_evicted_block,
    input logic [31:0]                  o_miss_total
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_miss_total) && $stable(o_hit))
        else $error("stalled result changed");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted_valid)
        else $error("hit with eviction");

    // No eviction means a zero block number
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted_valid |-> o_evicted_block == '0)
        else $error("evicted block not zero");

endmodule

bind fully_associative_lru_cache falru_checker u_falru_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_block (o_evicted_block),
    .o_miss_total    (o_miss_total)
);

// File: tb/fully_associative_lru_cache_test.sv
// Self-checking testbench for the fully associative LRU cache directory.
module fully_associative_lru_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                         hit;
        logic                         evicted_valid;
        logic [falru_pkg::ADDR_W-1:0] evicted_block;
        logic [31:0]                  miss_total;
    } t_lookup_result;

    // Tracks recency order and miss count, and checks each lookup result
    class lru_directory_scoreboard;
        logic [falru_pkg::ADDR_W-1:0] recency_order[$];  // index 0 is least recent
        t_lookup_result    pending_results[$];
        int unsigned       capacity_reg;
        logic [31:0]       miss_count;
        int unsigned       error_count;
        int unsigned       hit_count;
        int unsigned       evict_count;
        int unsigned       result_count;
        int unsigned       max_occupancy;

        function void reset_state();
            recency_order.delete();
            pending_results.delete();
            capacity_reg  = 1024;
            miss_count    = '0;
        endfunction

        function void set_capacity(logic [falru_pkg::CAP_W-1:0] value);
            capacity_reg = value;
        endfunction

        // Predict the result of one accepted lookup
        function void note_request(logic [falru_pkg::ADDR_W-1:0] addr);
            t_lookup_result exp_res;
            int unsigned    eff_cap;
            int             found_at;
            found_at = -1;
            eff_cap  = (capacity_reg == 0) ? 1 : capacity_reg;
            if (eff_cap > falru_pkg::ENTRIES) begin
                eff_cap = falru_pkg::ENTRIES;
            end
            foreach (recency_order[k]) begin
                if (found_at < 0 && recency_order[k] == addr) begin
                    found_at = k;
                end
            end
            exp_res.hit           = (found_at >= 0);
            exp_res.evicted_valid = 1'b0;
            exp_res.evicted_block = '0;
            if (found_at >= 0) begin
                // Move the block to most recent
                recency_order.delete(found_at);
                recency_order.push_back(addr);
            end else begin
                if (miss_count != falru_pkg::MISS_MAX) begin
                    miss_count++;
                end
                if (recency_order.size() >= eff_cap) begin
                    exp_res.evicted_valid = 1'b1;
                    exp_res.evicted_block = recency_order.pop_front();
                end
                recency_order.push_back(addr);
            end
            if (recency_order.size() > max_occupancy) begin
                max_occupancy = recency_order.size();
            end
            exp_res.miss_total = miss_count;
            pending_results.push_back(exp_res);
        endfunction

        // Compare one result with the oldest prediction
        function void check_result(t_lookup_result got);
            t_lookup_result exp_res;
            if (pending_results.size() == 0) begin
                $error("unexpected result: hit=%0b evicted=%0b block=%h misses=%0d",
                       got.hit, got.evicted_valid, got.evicted_block, got.miss_total);
                error_count++;
                return;
            end
            exp_res = pending_results.pop_front();
            result_count++;
            if (exp_res.hit) hit_count++;
            if (exp_res.evicted_valid) evict_count++;
            if (got.hit !== exp_res.hit) begin
                $error("hit: expected %0b, got %0b", exp_res.hit, got.hit);
                error_count++;
            end
            if (got.evicted_valid !== exp_res.evicted_valid) begin
                $error("evicted_valid: expected %0b, got %0b",
                       exp_res.evicted_valid, got.evicted_valid);
                error_count++;
            end
            if (got.evicted_block !== exp_res.evicted_block) begin
                $error("evicted_block: expected %h, got %h",
                       exp_res.evicted_block, got.evicted_block);
                error_count++;
            end
            if (got.miss_total !== exp_res.miss_total) begin
                $error("miss_total: expected %0d, got %0d",
                       exp_res.miss_total, got.miss_total);
                error_count++;
            end
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [falru_pkg::ADDR_W-1:0] i_block_address;
    logic                         o_valid;
    logic                         i_stall;
    logic                         o_hit;
    logic                         o_evicted_valid;
    logic [falru_pkg::ADDR_W-1:0] o_evicted_block;
    logic [31:0]                  o_miss_total;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [falru_pkg::CAP_W-1:0]  i_cfg_data;

    lru_directory_scoreboard      dir_sb;
    bit                           idle_enable;
    bit                           long_hold_req;
    int unsigned                  cycle_count;
    int unsigned                  sent_count;
    logic [falru_pkg::ADDR_W-1:0] pool_base;
    int unsigned                  pool_span;

    fully_associative_lru_cache u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_block_address (i_block_address),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_block (o_evicted_block),
        .o_miss_total    (o_miss_total),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Generate a 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive receiver stall in random bursts, with an occasional long hold
    int unsigned stall_left;
    int unsigned free_left;
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (free_left > 0 || !idle_enable) begin
            if (free_left > 0) free_left--;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            free_left = $urandom_range(0, 30);
            i_stall <= 1'b0;
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        t_lookup_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.hit           = o_hit;
            got.evicted_valid = o_evicted_valid;
            got.evicted_block = o_evicted_block;
            got.miss_total    = o_miss_total;
            dir_sb.check_result(got);
        end
    end

    // Offer one lookup, with an optional idle burst first, and hold until transfer
    task automatic send_lookup(logic [falru_pkg::ADDR_W-1:0] addr);
        int unsigned gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_block_address <= addr;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        dir_sb.note_request(addr);
        sent_count++;
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain_results();
        i_valid <= 1'b0;
        while (dir_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write the capacity register while the block is idle
    task automatic write_capacity(logic [falru_pkg::CAP_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dir_sb.set_capacity(value);
    endtask

    // Mostly reuse a small address pool so that hits are common
    function automatic logic [falru_pkg::ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 9) < 8) begin
            return pool_base + falru_pkg::ADDR_W'($urandom_range(0, pool_span));
        end
        return $urandom;
    endfunction

    task automatic run_phase(logic [falru_pkg::CAP_W-1:0] cap, int unsigned count,
                             int unsigned span);
        write_capacity(cap);
        pool_base = $urandom;
        pool_span = span;
        repeat (count) send_lookup(pick_address());
    endtask

    initial begin
        dir_sb = new();
        dir_sb.reset_state();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_block_address = '0;
        i_stall         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        idle_enable     = 1'b1;
        long_hold_req   = 1'b0;
        cycle_count     = 0;
        sent_count      = 0;
        stall_left      = 0;
        free_left       = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes and hits at each recency position, reset capacity
        send_lookup('0);
        send_lookup('1);
        send_lookup('1);               // hit on most recent
        send_lookup('0);               // hit on least recent
        send_lookup(32'hAAAA_AAAA);
        send_lookup(32'h5555_5555);
        send_lookup(32'h8000_0000);
        send_lookup(32'h0000_0001);
        send_lookup(32'hAAAA_AAAA);    // hit in the middle
        send_lookup('1);

        // Capacity of one: every miss evicts the least recently used block
        write_capacity(falru_pkg::CAP_W'(1));
        send_lookup(32'h0000_0001);
        send_lookup(32'h0000_0002);
        send_lookup(32'h0000_0002);
        send_lookup(32'hFFFF_FFFE);

        // Capacity zero acts as one
        write_capacity('0);
        send_lookup(32'h1234_5678);
        send_lookup(32'h1234_5678);
        send_lookup(32'h8765_4321);

        // Capacity above the entry count saturates
        run_phase('1, 40, 60);
        run_phase(falru_pkg::CAP_W'(1024), 60, 150);

        // Fill, then lower the capacity below occupancy
        run_phase(falru_pkg::CAP_W'(16), 40, 30);
        write_capacity(falru_pkg::CAP_W'(3));
        send_lookup(32'hDEAD_0001);
        send_lookup(32'hDEAD_0002);
        send_lookup(32'hDEAD_0001);
        send_lookup(32'hDEAD_0003);

        // Receiver holds off while the sender keeps offering
        write_capacity(falru_pkg::CAP_W'(8));
        long_hold_req = 1'b1;
        pool_base = $urandom;
        pool_span = 12;
        repeat (40) send_lookup(pick_address());

        // Sender pauses until every result has come
        drain_results();
        repeat (30) send_lookup(pick_address());

        // Random phases, mostly small capacities
        repeat (13) begin
            logic [falru_pkg::CAP_W-1:0] cap;
            cap = ($urandom_range(0, 3) == 0) ? falru_pkg::CAP_W'($urandom_range(1, 4))
                                              : falru_pkg::CAP_W'($urandom_range(1, 64));
            run_phase(cap, 110, 2 * cap + $urandom_range(0, 8));
        end

        // Final stretch without idling on either side
        write_capacity(falru_pkg::CAP_W'(24));
        idle_enable = 1'b0;
        pool_base = $urandom;
        repeat (150) send_lookup(pick_address());
        drain_results();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d lookups: %0d hits, %0d evictions, peak occupancy %0d.",
                 sent_count, dir_sb.hit_count, dir_sb.evict_count, dir_sb.max_occupancy);
        $display("Capacities from zero to the register maximum, long stall and drain pauses.");
        if (dir_sb.error_count == 0 && dir_sb.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
